// ----- hw/rtl/mld_pkg.sv -----
`default_nettype none
package mld_pkg;

	localparam int POS_W = 9;

	localparam logic [7:0] MAGIC_FIRST  = 8'h57;  // 'W'
	localparam logic [7:0] MAGIC_SECOND = 8'h31;  // '1'

	// header offsets of the little-endian payload length
	localparam int LEN_LOW_AT  = 12;
	localparam int LEN_HIGH_AT = 13;

	typedef enum logic [3:0] {
		PH_HUNT   = 4'b0001,
		PH_MAGIC2 = 4'b0010,
		PH_HEADER = 4'b0100,
		PH_BODY   = 4'b1000
	} phase_t;

	typedef struct packed {
		logic             valid;
		logic [7:0]       data;
		logic [POS_W-1:0] position;
		logic             last;
		logic             drop;
	} result_t;

endpackage
`default_nettype wire

// ----- hw/rtl/mld_step.sv -----
`default_nettype none
module mld_step #(
	parameter int HEADER_BYTES = 16,
	parameter int MAX_PAYLOAD  = 256,
	parameter int CRC_BYTES    = 4,
	parameter int CNT_W        = 9
) (
	input  mld_pkg::phase_t  phase,
	input  logic [CNT_W-1:0] byte_count,
	input  logic [7:0]       len_low,
	input  logic [CNT_W-1:0] frame_end,
	input  logic [7:0]       rx_byte,
	output mld_pkg::phase_t  phase_nxt,
	output logic [CNT_W-1:0] byte_count_nxt,
	output logic [7:0]       len_low_nxt,
	output logic [CNT_W-1:0] frame_end_nxt,
	output mld_pkg::result_t res
);
	import mld_pkg::*;

	logic [CNT_W-1:0] pos_inc;
	logic [15:0]      len;
	logic             oversize;
	logic [CNT_W-1:0] fe_calc;

	assign pos_inc  = byte_count + CNT_W'(1);
	assign len      = {rx_byte, len_low};
	assign oversize = len > 16'(MAX_PAYLOAD);
	// zero frame_end marks an oversize length
	assign fe_calc  = oversize ? '0 : CNT_W'(HEADER_BYTES + CRC_BYTES) + CNT_W'(len);

	always_comb begin
		phase_nxt      = phase;
		byte_count_nxt = byte_count;
		len_low_nxt    = len_low;
		frame_end_nxt  = frame_end;
		res            = '0;
		res.data       = rx_byte;
		res.position   = byte_count[POS_W-1:0];
		unique case (phase)
			PH_HUNT: begin
				if (rx_byte == MAGIC_FIRST) begin
					res.valid      = 1'b1;
					res.position   = '0;
					byte_count_nxt = CNT_W'(1);
					phase_nxt      = PH_MAGIC2;
				end
			end
			PH_MAGIC2: begin
				res.valid    = 1'b1;
				res.position = POS_W'(1);
				if (rx_byte != MAGIC_SECOND) begin
					// abandoned; this byte is not rechecked as a 'W'
					res.drop       = 1'b1;
					byte_count_nxt = '0;
					phase_nxt      = PH_HUNT;
				end else begin
					byte_count_nxt = CNT_W'(2);
					phase_nxt      = PH_HEADER;
				end
			end
			PH_HEADER: begin
				res.valid = 1'b1;
				if (byte_count == CNT_W'(LEN_LOW_AT))
					len_low_nxt = rx_byte;
				if (byte_count == CNT_W'(LEN_HIGH_AT))
					frame_end_nxt = fe_calc;
				if (pos_inc >= CNT_W'(HEADER_BYTES)) begin
					if (frame_end_nxt == '0) begin
						res.drop       = 1'b1;
						byte_count_nxt = '0;
						phase_nxt      = PH_HUNT;
					end else if (frame_end_nxt <= pos_inc) begin
						// empty body and no CRC
						res.last       = 1'b1;
						byte_count_nxt = '0;
						phase_nxt      = PH_HUNT;
					end else begin
						byte_count_nxt = pos_inc;
						phase_nxt      = PH_BODY;
					end
				end else begin
					byte_count_nxt = pos_inc;
				end
			end
			PH_BODY: begin
				res.valid = 1'b1;
				if (pos_inc >= frame_end) begin
					res.last       = 1'b1;
					byte_count_nxt = '0;
					phase_nxt      = PH_HUNT;
				end else begin
					byte_count_nxt = pos_inc;
				end
			end
			default: begin
				byte_count_nxt = '0;
				phase_nxt      = PH_HUNT;
			end
		endcase
	end

endmodule
`default_nettype wire

// ----- hw/rtl/magic_length_frame_deframer_top.sv -----
// An accepted item's result passes through the input register, then the result
// register; items that are noise give no result.
// Throughput: one item per cycle while out_stall is low, set by the state update between
// the input register and the result register.
// Reset (arst_n low, asynchronous): hunting for 'W', counters and length cleared,
// both pipeline stages empty.
`default_nettype none
module magic_length_frame_deframer_top #(
	parameter int HEADER_BYTES = 16,
	parameter int MAX_PAYLOAD  = 256,
	parameter int CRC_BYTES    = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] rx_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] data,
	output logic [8:0] position,
	output logic       frame_last,
	output logic       frame_drop
);
	import mld_pkg::*;

	localparam int FrameMax = HEADER_BYTES + MAX_PAYLOAD + CRC_BYTES;
	localparam int CntRaw   = $clog2(FrameMax + 1);
	localparam int CntW     = (CntRaw > POS_W) ? CntRaw : POS_W;

	logic             valid_s1;
	logic [7:0]       rx_byte_s1;
	logic             valid_s2;
	result_t          res_s2;

	phase_t           phase_q;
	logic [CntW-1:0]  byte_count_q;
	logic [7:0]       len_low_q;
	logic [CntW-1:0]  frame_end_q;

	phase_t           phase_nxt;
	logic [CntW-1:0]  byte_count_nxt;
	logic [7:0]       len_low_nxt;
	logic [CntW-1:0]  frame_end_nxt;
	result_t          res;

	logic             in_fire;
	logic             s2_ready;
	logic             s1_fire;

	assign s2_ready = !valid_s2 || !out_stall;
	assign s1_fire  = valid_s1 && s2_ready;
	assign in_stall = valid_s1 && !s1_fire;
	assign in_fire  = in_valid && !in_stall;

	mld_step #(
		.HEADER_BYTES(HEADER_BYTES),
		.MAX_PAYLOAD (MAX_PAYLOAD),
		.CRC_BYTES   (CRC_BYTES),
		.CNT_W       (CntW)
	) u_step (
		.phase         (phase_q),
		.byte_count    (byte_count_q),
		.len_low       (len_low_q),
		.frame_end     (frame_end_q),
		.rx_byte       (rx_byte_s1),
		.phase_nxt     (phase_nxt),
		.byte_count_nxt(byte_count_nxt),
		.len_low_nxt   (len_low_nxt),
		.frame_end_nxt (frame_end_nxt),
		.res           (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1     <= 1'b0;
			valid_s2     <= 1'b0;
			phase_q      <= PH_HUNT;
			byte_count_q <= '0;
			len_low_q    <= '0;
			frame_end_q  <= '0;
		end else begin
			if (in_fire)
				valid_s1 <= 1'b1;
			else if (s1_fire)
				valid_s1 <= 1'b0;

			if (s1_fire) begin
				valid_s2     <= res.valid;
				phase_q      <= phase_nxt;
				byte_count_q <= byte_count_nxt;
				len_low_q    <= len_low_nxt;
				frame_end_q  <= frame_end_nxt;
			end else if (!out_stall) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire)
			rx_byte_s1 <= rx_byte;
		if (s1_fire && res.valid)
			res_s2 <= res;
	end

	assign out_valid  = valid_s2;
	assign data       = res_s2.data;
	assign position   = res_s2.position;
	assign frame_last = res_s2.last;
	assign frame_drop = res_s2.drop;

endmodule
`default_nettype wire

// ----- bench/tb_top.sv -----
`default_nettype none
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import mld_pkg::*;

	localparam int HDR_BYTES   = 16;
	localparam int MAX_LEN     = 256;
	localparam int CHECK_BYTES = 4;
	localparam int RESULT_GOAL = 1950;
	localparam int HOLD_CYCLES = 300;
	localparam int TAIL_CYCLES = 10;

	typedef enum logic [1:0] {
		STALL_NONE,
		STALL_LIGHT,
		STALL_PERIODIC,
		STALL_HEAVY
	} stall_mode_t;

	// Tracks the frame state of the received byte stream and holds the output
	// items it implies, oldest first.
	class deframe_predictor;
		phase_t     state;
		int         offset;
		logic [7:0] len_low;
		int         end_at;
		result_t    due[$];
		int         mismatches;
		int         produced;

		function new();
			state      = PH_HUNT;
			offset     = 0;
			len_low    = 8'h00;
			end_at     = 0;
			mismatches = 0;
			produced   = 0;
		endfunction

		function int pending();
			return due.size();
		endfunction

		function void emit(logic [7:0] b, int pos, logic last, logic drop);
			result_t r;
			r.valid    = 1'b1;
			r.data     = b;
			r.position = pos[POS_W-1:0];
			r.last     = last;
			r.drop     = drop;
			due.push_back(r);
			produced++;
		endfunction

		function void restart();
			offset = 0;
			state  = PH_HUNT;
		endfunction

		function void take_rx_byte(logic [7:0] b);
			int frame_len;
			case (state)
				PH_HUNT: begin
					if (b == MAGIC_FIRST) begin
						emit(b, 0, 1'b0, 1'b0);
						offset = 1;
						state  = PH_MAGIC2;
					end
				end
				PH_MAGIC2: begin
					if (b != MAGIC_SECOND) begin
						emit(b, 1, 1'b0, 1'b1);
						restart();
					end else begin
						emit(b, 1, 1'b0, 1'b0);
						offset = 2;
						state  = PH_HEADER;
					end
				end
				PH_HEADER: begin
					if (offset == LEN_LOW_AT)
						len_low = b;
					if (offset == LEN_HIGH_AT) begin
						frame_len = int'({b, len_low});
						// zero end marks an oversize length
						end_at = (frame_len > MAX_LEN) ? 0 : HDR_BYTES + frame_len + CHECK_BYTES;
					end
					if (offset + 1 >= HDR_BYTES) begin
						if (end_at == 0) begin
							emit(b, offset, 1'b0, 1'b1);
							restart();
						end else if (end_at <= offset + 1) begin
							emit(b, offset, 1'b1, 1'b0);
							restart();
						end else begin
							emit(b, offset, 1'b0, 1'b0);
							offset++;
							state = PH_BODY;
						end
					end else begin
						emit(b, offset, 1'b0, 1'b0);
						offset++;
					end
				end
				default: begin
					if (offset + 1 >= end_at) begin
						emit(b, offset, 1'b1, 1'b0);
						restart();
					end else begin
						emit(b, offset, 1'b0, 1'b0);
						offset++;
					end
				end
			endcase
		endfunction

		function void match_output(logic [7:0] d, logic [8:0] p, logic l, logic dr);
			result_t e;
			if (due.size() == 0) begin
				$error("unexpected item: data %0h position %0d", d, p);
				mismatches++;
				return;
			end
			e = due.pop_front();
			if (d !== e.data) begin
				$error("data: expected %0h, actual %0h", e.data, d);
				mismatches++;
			end
			if (p !== e.position) begin
				$error("position: expected %0d, actual %0d", e.position, p);
				mismatches++;
			end
			if (l !== e.last) begin
				$error("frame_last: expected %0b, actual %0b", e.last, l);
				mismatches++;
			end
			if (dr !== e.drop) begin
				$error("frame_drop: expected %0b, actual %0b", e.drop, dr);
				mismatches++;
			end
		endfunction
	endclass

	logic       clk       = 1'b0;
	logic       arst_n    = 1'b0;
	logic       in_valid  = 1'b0;
	logic [7:0] rx_byte   = 8'h00;
	logic       out_stall = 1'b0;
	logic       in_stall;
	logic       out_valid;
	logic [7:0] data;
	logic [8:0] position;
	logic       frame_last;
	logic       frame_drop;

	// handshake state sampled mid-cycle, used at the following rising edge
	bit         in_take;
	bit         out_take;
	logic [7:0] data_s;
	logic [8:0] position_s;
	logic       last_s;
	logic       drop_s;

	bit hold_req  = 1'b0;
	bit hold_done = 1'b0;
	bit steady    = 1'b0;
	int burst_left = 0;

	deframe_predictor frames = new();

	magic_length_frame_deframer_top #(
		.HEADER_BYTES(HDR_BYTES),
		.MAX_PAYLOAD (MAX_LEN),
		.CRC_BYTES   (CHECK_BYTES)
	) uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.rx_byte   (rx_byte),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.data      (data),
		.position  (position),
		.frame_last(frame_last),
		.frame_drop(frame_drop)
	);

	always #1 clk = ~clk;

	always @(negedge clk) begin
		in_take    = in_valid && !in_stall;
		out_take   = out_valid && !out_stall;
		data_s     = data;
		position_s = position;
		last_s     = frame_last;
		drop_s     = frame_drop;
	end

	always @(posedge clk) begin
		if (out_take)
			frames.match_output(data_s, position_s, last_s, drop_s);
	end

	// receiver stall pattern, with a long hold-off on request
	initial begin
		stall_mode_t mode;
		int mode_left;
		int hold_left;
		int period;
		int tick;
		mode      = STALL_NONE;
		mode_left = 0;
		hold_left = 0;
		period    = 2;
		tick      = 0;
		forever begin
			@(posedge clk);
			tick++;
			if (hold_req) begin
				hold_req  = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				if (mode_left == 0) begin
					mode      = stall_mode_t'($urandom_range(0, 3));
					mode_left = $urandom_range(20, 200);
					period    = $urandom_range(2, 5);
				end
				mode_left--;
				case (mode)
					STALL_NONE:     out_stall <= 1'b0;
					STALL_LIGHT:    out_stall <= ($urandom_range(0, 99) < 30);
					STALL_PERIODIC: out_stall <= ((tick % period) == 0);
					default:        out_stall <= ($urandom_range(0, 99) < 75);
				endcase
			end
		end
	end

	task automatic push_byte(input logic [7:0] b);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			if (!steady) begin
				in_valid <= 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
			end
		end
		burst_left--;
		in_valid <= 1'b1;
		rx_byte  <= b;
		do @(posedge clk); while (!in_take);
		frames.take_rx_byte(b);
	endtask

	task automatic idle_until_drained();
		in_valid   <= 1'b0;
		burst_left = 0;
		do @(posedge clk); while (frames.pending() != 0);
	endtask

	task automatic send_frame(input int len_field, input int body_len);
		logic [15:0] lf;
		int i;
		lf = len_field[15:0];
		push_byte(MAGIC_FIRST);
		push_byte(MAGIC_SECOND);
		for (i = 2; i < HDR_BYTES; i++) begin
			if (i == LEN_LOW_AT)
				push_byte(lf[7:0]);
			else if (i == LEN_HIGH_AT)
				push_byte(lf[15:8]);
			else
				push_byte(8'($urandom));
		end
		for (i = 0; i < body_len; i++)
			push_byte(8'($urandom));
	endtask

	initial begin
		int choice;
		int pick;
		int len;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// noise while hunting
		push_byte(8'h00);
		push_byte(8'hFF);
		push_byte(MAGIC_SECOND);
		push_byte(MAGIC_FIRST - 8'd1);
		push_byte(MAGIC_FIRST + 8'd1);
		// bad second magic
		push_byte(MAGIC_FIRST);
		push_byte(8'h00);
		// a second 'W' drops the frame; the '1' after it is plain noise
		push_byte(MAGIC_FIRST);
		push_byte(MAGIC_FIRST);
		push_byte(MAGIC_SECOND);
		send_frame(0, CHECK_BYTES);
		send_frame(MAX_LEN + 1, 0);

		idle_until_drained();
		hold_req = 1'b1;
		send_frame(MAX_LEN, MAX_LEN + CHECK_BYTES);
		send_frame(int'(16'hFFFF), 2);

		while (frames.produced < RESULT_GOAL) begin
			if (!hold_done && frames.produced > RESULT_GOAL / 2) begin
				idle_until_drained();
				hold_req  = 1'b1;
				hold_done = 1'b1;
			end
			steady = ($urandom_range(0, 9) < 3);
			choice = $urandom_range(0, 99);
			pick   = $urandom_range(0, 99);
			if (choice < 70) begin
				if (pick < 70)
					len = $urandom_range(0, 12);
				else if (pick < 85)
					len = $urandom_range(13, 64);
				else if (pick < 94)
					len = $urandom_range(65, MAX_LEN - 1);
				else
					len = MAX_LEN;
				send_frame(len, len + CHECK_BYTES);
			end else if (choice < 78) begin
				if (pick < 30)
					len = MAX_LEN + 1;
				else if (pick < 50)
					len = int'(16'hFFFF);
				else
					len = $urandom_range(MAX_LEN + 1, 32'h0000_FFFF);
				// trailing bytes land in the hunt
				send_frame(len, $urandom_range(0, 4));
			end else if (choice < 86) begin
				push_byte(MAGIC_FIRST);
				push_byte(8'($urandom));
			end else if (choice < 93) begin
				repeat ($urandom_range(1, 8)) push_byte(8'($urandom));
			end else begin
				// cut-off frame: whatever follows is taken as the rest of it
				push_byte(MAGIC_FIRST);
				push_byte(MAGIC_SECOND);
				repeat ($urandom_range(0, 20)) push_byte(8'($urandom));
			end
		end

		idle_until_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (frames.mismatches == 0 && frames.pending() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	initial begin
		#1_000_000;
		$display("Regression FAIL");
		$finish;
	end

endmodule
`default_nettype wire
